>>> rtl/core/deq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_pkg: shared types for the double-ended queue
// Operation and status codes, the request beat that passes from the input
// stage to the execute stage, and the result beat.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int WORD_W  = 32;
    localparam int OP_W    = 3;
    localparam int COUNT_W = 9;
    localparam int STAT_W  = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ADD_FRONT    = 3'd0,
        OP_ADD_BACK     = 3'd1,
        OP_REMOVE_FRONT = 3'd2,
        OP_REMOVE_BACK  = 3'd3,
        OP_PEEK         = 3'd4
    } deq_op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } deq_status_t;

    // one accepted request beat
    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic signed [WORD_W-1:0] value;
    } deq_item_t;

    // one result beat
    typedef struct packed {
        logic signed [WORD_W-1:0] removed_value;
        logic signed [WORD_W-1:0] first_value;
        logic signed [WORD_W-1:0] last_value;
        logic [COUNT_W-1:0]       item_count;
        deq_status_t              status;
    } deq_result_t;

endpackage

>>> rtl/core/double_ended_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue: bounded deque of signed 32-bit words
// Ring of DEPTH slots with front/back indexes and a word count. Each request
// beat adds or removes at either end, or peeks; each gives one result beat.
// ----------------------------------------------------------------------------
//
//   channel   handshake             payload
//   -------   -------------------   ---------------------------------------
//   request   in_valid / in_ready   operation[2:0], value[31:0]
//   result    out_valid/out_ready   removed_value, first_value, last_value,
//                                   item_count[8:0], status[1:0]
//
// Flow: one request per cycle sustained while out_ready stays high. An
//   accepted request is loaded into the input register and then into the
//   result register, which raises out_valid.
// The rate is set by the slot store's two read ports: the neighbors of the
//   new ends are read during each request, ready for the next one.
// Reset (rst_n low, async): ring empty, front index 0, no beats held; the
//   slot store is not cleared; a slot is only used after being written.
// Stalls: with out_ready low one finished result waits in the result
//   register while one more request is held in the input register.
//
module double_ended_queue
    import deq_pkg::*;
#(
    parameter int DEPTH = 256
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [OP_W-1:0]           operation,
    input  logic signed [WORD_W-1:0]  value,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [WORD_W-1:0]  removed_value,
    output logic signed [WORD_W-1:0]  first_value,
    output logic signed [WORD_W-1:0]  last_value,
    output logic [COUNT_W-1:0]        item_count,
    output logic [STAT_W-1:0]         status
);

    // slot index and count widths follow the depth
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic                     item_valid;
    deq_item_t                item;
    logic                     item_take;
    deq_result_t              res;

    logic                     mem_we;
    logic [AW-1:0]            mem_waddr;
    logic signed [WORD_W-1:0] mem_wdata;
    logic                     mem_re;
    logic [AW-1:0]            mem_raddr_a;
    logic [AW-1:0]            mem_raddr_b;
    logic signed [WORD_W-1:0] next_front_word;
    logic signed [WORD_W-1:0] next_back_word;

    // request beat register
    deq_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .value      (value),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    // slot store: at most one write, two prefetch reads per request
    deq_ring_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ring_mem (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .re      (mem_re),
        .raddr_a (mem_raddr_a),
        .raddr_b (mem_raddr_b),
        .rdata_a (next_front_word),
        .rdata_b (next_back_word)
    );

    // pointer update, end-word cache and result beat
    deq_exec #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_exec (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item            (item),
        .item_take       (item_take),
        .res_valid       (out_valid),
        .res             (res),
        .res_ready       (out_ready),
        .mem_we          (mem_we),
        .mem_waddr       (mem_waddr),
        .mem_wdata       (mem_wdata),
        .mem_re          (mem_re),
        .mem_raddr_a     (mem_raddr_a),
        .mem_raddr_b     (mem_raddr_b),
        .next_front_word (next_front_word),
        .next_back_word  (next_back_word)
    );

    assign removed_value = res.removed_value;
    assign first_value   = res.first_value;
    assign last_value    = res.last_value;
    assign item_count    = res.item_count;
    assign status        = res.status;

endmodule

>>> rtl/core/deq_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_in_reg: request input register
// Holds one request beat; refills in the same cycle it is taken.
// ----------------------------------------------------------------------------
module deq_in_reg
    import deq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [OP_W-1:0]          operation,
    input  logic signed [WORD_W-1:0] value,
    output logic                     item_valid,
    output deq_item_t                item,
    input  logic                     item_take
);

    logic      valid_reg;
    deq_item_t item_reg;
    logic      load;

    assign in_ready   = !valid_reg || item_take;
    assign load       = in_valid && in_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.op    <= operation;
            item_reg.value <= value;
        end
    end

endmodule

>>> rtl/core/deq_ring_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_ring_mem: slot store of the ring
// One write port, two registered read ports; a read of the slot being
// written in the same cycle returns the new word.
// ----------------------------------------------------------------------------
module deq_ring_mem
    import deq_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int AW    = 8
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [AW-1:0]            waddr,
    input  logic signed [WORD_W-1:0] wdata,
    input  logic                     re,
    input  logic [AW-1:0]            raddr_a,
    input  logic [AW-1:0]            raddr_b,
    output logic signed [WORD_W-1:0] rdata_a,
    output logic signed [WORD_W-1:0] rdata_b
);

    logic signed [WORD_W-1:0] slot_store [DEPTH];
    logic signed [WORD_W-1:0] rdata_a_reg;
    logic signed [WORD_W-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            slot_store[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a_reg <= (we && (waddr == raddr_a)) ? wdata : slot_store[raddr_a];
            rdata_b_reg <= (we && (waddr == raddr_b)) ? wdata : slot_store[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

>>> rtl/core/deq_exec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_exec: ring pointers, end-word cache and result register
// Executes one request per cycle if not stalled. Front and back words live
// in registers; their inner neighbors are prefetched from the slot store.
// ----------------------------------------------------------------------------
module deq_exec
    import deq_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int CW    = 9
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     item_valid,
    input  deq_item_t                item,
    output logic                     item_take,
    output logic                     res_valid,
    output deq_result_t              res,
    input  logic                     res_ready,
    output logic                     mem_we,
    output logic [AW-1:0]            mem_waddr,
    output logic signed [WORD_W-1:0] mem_wdata,
    output logic                     mem_re,
    output logic [AW-1:0]            mem_raddr_a,
    output logic [AW-1:0]            mem_raddr_b,
    input  logic signed [WORD_W-1:0] next_front_word,
    input  logic signed [WORD_W-1:0] next_back_word
);

    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] idx);
        idx_inc = (idx == LAST_IDX) ? '0 : idx + 1'b1;
    endfunction

    function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] idx);
        idx_dec = (idx == '0) ? LAST_IDX : idx - 1'b1;
    endfunction

    logic [AW-1:0]            front_reg, front_next;
    logic [AW-1:0]            back_reg, back_next;
    logic [CW-1:0]            count_reg, count_next;
    logic signed [WORD_W-1:0] first_reg, first_next;
    logic signed [WORD_W-1:0] last_reg, last_next;
    logic                     res_valid_reg;
    deq_result_t              res_reg, res_next;
    logic                     exec_fire;
    logic                     empty, full;
    logic [AW-1:0]            back_inc;

    assign exec_fire = item_valid && (!res_valid_reg || res_ready);
    assign item_take = exec_fire;
    assign empty     = (count_reg == '0);
    assign full      = (count_reg == FULL_CNT);
    assign back_inc  = idx_inc(back_reg);

    always_comb
    begin
        front_next = front_reg;
        back_next  = back_reg;
        count_next = count_reg;
        first_next = first_reg;
        last_next  = last_reg;
        mem_we     = 1'b0;
        mem_waddr  = idx_dec(front_reg);
        mem_wdata  = item.value;
        res_next   = '0;
        res_next.status = ST_OK;

        case (deq_op_t'(item.op))
            OP_ADD_FRONT:
            begin
                if (full)
                begin
                    res_next.status = ST_OVERFLOW;
                end
                else
                begin
                    mem_we     = exec_fire;
                    front_next = idx_dec(front_reg);
                    count_next = count_reg + 1'b1;
                    first_next = item.value;
                    if (empty)
                    begin
                        last_next = item.value;
                    end
                end
            end
            OP_ADD_BACK:
            begin
                mem_waddr = back_inc;
                if (full)
                begin
                    res_next.status = ST_OVERFLOW;
                end
                else
                begin
                    mem_we     = exec_fire;
                    back_next  = back_inc;
                    count_next = count_reg + 1'b1;
                    last_next  = item.value;
                    if (empty)
                    begin
                        first_next = item.value;
                    end
                end
            end
            OP_REMOVE_FRONT:
            begin
                if (empty)
                begin
                    res_next.status = ST_UNDERFLOW;
                end
                else
                begin
                    res_next.removed_value = first_reg;
                    front_next = idx_inc(front_reg);
                    count_next = count_reg - 1'b1;
                    first_next = next_front_word;
                end
            end
            OP_REMOVE_BACK:
            begin
                if (empty)
                begin
                    res_next.status = ST_UNDERFLOW;
                end
                else
                begin
                    res_next.removed_value = last_reg;
                    back_next  = idx_dec(back_reg);
                    count_next = count_reg - 1'b1;
                    last_next  = next_back_word;
                end
            end
            default:
            begin
                // peek and unused codes leave the state alone
            end
        endcase

        res_next.item_count = COUNT_W'(count_next);
        if (count_next != '0)
        begin
            res_next.first_value = first_next;
            res_next.last_value  = last_next;
        end
    end

    // prefetch the inner neighbors of the new ends
    assign mem_re      = exec_fire;
    assign mem_raddr_a = idx_inc(front_next);
    assign mem_raddr_b = idx_dec(back_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            back_reg      <= LAST_IDX;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (exec_fire)
            begin
                front_reg <= front_next;
                back_reg  <= back_next;
                count_reg <= count_next;
            end
            if (exec_fire)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_fire)
        begin
            first_reg <= first_next;
            last_reg  <= last_next;
            res_reg   <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // ring bookkeeping: back sits just before front when empty
    a_empty_ring: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (front_reg == back_inc))
        else $error("empty ring with back not adjacent to front");

    a_single_ring: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == CW'(1)) |-> (front_reg == back_reg))
        else $error("single word ring with front and back apart");

    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !exec_fire |=> ($stable(count_reg) && $stable(front_reg) && $stable(back_reg)))
        else $error("ring state moved without a request");

    a_write_grows: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (exec_fire && (count_next == count_reg + 1'b1)))
        else $error("slot write without a matching add");

endmodule

>>> dv/double_ended_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_tb: self-checking bench for the bounded deque
// Request beats come from a queue that is built up front and drained by a
// clocked driver. A clocked monitor runs each accepted request through a
// software ring model and checks every result beat against it, field by
// field. Both sides throttle at random, and there is one long receiver stall.
// ----------------------------------------------------------------------------
module double_ended_queue_tb;
    import deq_pkg::*;

    localparam int RING_SLOTS   = 256;
    localparam int RANDOM_ITEMS = 1550;
    localparam int REPORT_MAX   = 10;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 20;

    // op codes above peek are spare; the block treats them as a peek
    localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

    // random segment flavors
    localparam int SEG_FILL  = 0;
    localparam int SEG_DRAIN = 1;
    localparam int SEG_MIXED = 2;

    // throttle phases
    localparam int PH_SLOW_SINK = 0;
    localparam int PH_SLOW_SRC  = 1;
    localparam int PH_FULL_RATE = 2;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [OP_W-1:0]          operation = '0;
    logic signed [WORD_W-1:0] value = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [WORD_W-1:0] removed_value;
    logic signed [WORD_W-1:0] first_value;
    logic signed [WORD_W-1:0] last_value;
    logic [COUNT_W-1:0]       item_count;
    logic [STAT_W-1:0]        status;

    double_ended_queue #(.DEPTH(RING_SLOTS)) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .removed_value(removed_value),
        .first_value  (first_value),
        .last_value   (last_value),
        .item_count   (item_count),
        .status       (status)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    deq_item_t   pending_reqs[$];   // request beats not yet offered
    deq_result_t expected_res[$];   // predicted results, oldest first

    // ring model: head slot, word count, and the words themselves
    logic signed [WORD_W-1:0] ring_words [RING_SLOTS];
    logic [7:0]               ring_head = '0;
    logic [8:0]               ring_fill = '0;

    bit req_fire = 1'b0;    // request beat taken at the last rising edge
    int req_total = 0;      // requests queued for the whole run
    int req_taken = 0;      // requests accepted so far (updated with NBA)
    int res_checked = 0;
    int error_count = 0;
    int overflow_hits = 0;
    int underflow_hits = 0;
    int peak_fill = 0;
    int throttle_phase = PH_SLOW_SINK;

    int hold_at = 0;        // request count at which the long stall begins
    int hold_left = 0;
    bit hold_done = 1'b0;

    // ------------------------------------------------------------------
    // Ring model: apply one request and return the result it should give.
    // Head moves back on an add at the front and forward on a remove at the
    // front; the back slot is always head + fill - 1, mod 256.
    // ------------------------------------------------------------------
    function automatic deq_result_t deque_apply(deq_item_t req);
        deq_result_t res;
        logic [7:0]  slot;
        res = '0;
        res.status = ST_OK;
        case (req.op)
            OP_ADD_FRONT, OP_ADD_BACK:
            begin
                if (ring_fill == RING_SLOTS)
                begin
                    res.status = ST_OVERFLOW;   // full: word dropped
                end
                else if (req.op == OP_ADD_FRONT)
                begin
                    ring_head = ring_head - 8'd1;
                    ring_words[ring_head] = req.value;
                    ring_fill = ring_fill + 9'd1;
                end
                else
                begin
                    slot = ring_head + ring_fill[7:0];
                    ring_words[slot] = req.value;
                    ring_fill = ring_fill + 9'd1;
                end
            end
            OP_REMOVE_FRONT, OP_REMOVE_BACK:
            begin
                if (ring_fill == 0)
                begin
                    res.status = ST_UNDERFLOW;  // empty: nothing changes
                end
                else if (req.op == OP_REMOVE_FRONT)
                begin
                    res.removed_value = ring_words[ring_head];
                    ring_head = ring_head + 8'd1;
                    ring_fill = ring_fill - 9'd1;
                end
                else
                begin
                    slot = ring_head + ring_fill[7:0] - 8'd1;
                    res.removed_value = ring_words[slot];
                    ring_fill = ring_fill - 9'd1;
                end
            end
            default:
            begin
                // peek and the spare codes leave the ring alone
            end
        endcase
        if (ring_fill != 0)
        begin
            slot = ring_head + ring_fill[7:0] - 8'd1;
            res.first_value = ring_words[ring_head];
            res.last_value  = ring_words[slot];
        end
        res.item_count = ring_fill;
        return res;
    endfunction

    function automatic deq_item_t make_req(logic [OP_W-1:0] op,
                                           logic signed [WORD_W-1:0] word);
        deq_item_t req;
        req.op = op;
        req.value = word;
        return req;
    endfunction

    task automatic note_mismatch(string what, logic [WORD_W-1:0] want,
                                 logic [WORD_W-1:0] got);
        error_count++;
        if (error_count <= REPORT_MAX)
            $display("[%0t] mismatch on %s: expected %h, got %h",
                     $time, what, want, got);
    endtask

    // Queue one random segment. Fill and drain segments are mostly adds or
    // removes with random ends and words; mixed ones wander around the
    // middle. A few peeks and spare codes are sprinkled into all of them.
    task automatic queue_segment(int flavor, int len);
        int                       roll;
        int                       add_cut;
        int                       rem_cut;
        logic [OP_W-1:0]          op;
        logic signed [WORD_W-1:0] word;
        add_cut = (flavor == SEG_FILL) ? 92 : (flavor == SEG_DRAIN) ? 5 : 40;
        rem_cut = (flavor == SEG_MIXED) ? 80 : 97;
        for (int i = 0; i < len; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < add_cut)
                op = $urandom_range(0, 1) ? OP_ADD_FRONT : OP_ADD_BACK;
            else if (roll < rem_cut)
                op = $urandom_range(0, 1) ? OP_REMOVE_FRONT : OP_REMOVE_BACK;
            else if ($urandom_range(0, 1))
                op = OP_PEEK;
            else
                op = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
            // every so often a word at the edge of the signed range
            case ($urandom_range(0, 15))
                0:       word = 32'sh7FFF_FFFF;
                1:       word = 32'sh8000_0000;
                2:       word = 32'sh0000_0000;
                3:       word = -32'sd1;
                default: word = $urandom;
            endcase
            pending_reqs.push_back(make_req(op, word));
        end
    endtask

    // ------------------------------------------------------------------
    // Request driver: inputs move on the falling edge. A beat on offer is
    // held until the monitor sees it taken; otherwise the next one goes out
    // unless the sender idles this cycle.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        deq_item_t nxt;
        bit        idle_now;
        if (rst_n && !(in_valid && !req_fire))
        begin
            idle_now = (throttle_phase == PH_SLOW_SINK) ? ($urandom_range(0, 99) < 19) :
                       (throttle_phase == PH_SLOW_SRC)  ? ($urandom_range(0, 99) < 68) :
                       1'b0;
            if (pending_reqs.size() != 0 && !idle_now)
            begin
                nxt = pending_reqs.pop_front();
                operation <= nxt.op;
                value     <= nxt.value;
                in_valid  <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result receiver: ready is dropped at random per phase, and held low
    // for the whole long stall.
    always @(negedge clk)
    begin
        if (!rst_n || hold_left != 0)
            out_ready <= 1'b0;
        else if (throttle_phase == PH_SLOW_SINK)
            out_ready <= ($urandom_range(0, 99) >= 68);
        else if (throttle_phase == PH_SLOW_SRC)
            out_ready <= ($urandom_range(0, 99) >= 19);
        else
            out_ready <= 1'b1;
    end

    // Phase tracks progress through the request stream.
    always @(negedge clk)
    begin
        if (req_taken < req_total / 3)
            throttle_phase = PH_SLOW_SINK;
        else if (req_taken < (2 * req_total) / 3)
            throttle_phase = PH_SLOW_SRC;
        else
            throttle_phase = PH_FULL_RATE;
    end

    // Long receiver stall, counted here. It starts in the full-rate phase,
    // so the sender keeps offering and the block backs up into in_ready.
    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (!hold_done && hold_at != 0 && req_taken >= hold_at)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: everything sampled at the rising edge. Results are checked
    // before this edge's request is predicted; a request's own result can
    // never show up on the same edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        deq_result_t want;
        deq_item_t   req;
        req_fire = 1'b0;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_res.size() == 0)
                begin
                    note_mismatch("result beat with nothing expected", '0, removed_value);
                end
                else
                begin
                    want = expected_res.pop_front();
                    res_checked++;
                    if (removed_value !== want.removed_value)
                        note_mismatch("removed_value", want.removed_value, removed_value);
                    if (first_value !== want.first_value)
                        note_mismatch("first_value", want.first_value, first_value);
                    if (last_value !== want.last_value)
                        note_mismatch("last_value", want.last_value, last_value);
                    if (item_count !== want.item_count)
                        note_mismatch("item_count", WORD_W'(want.item_count),
                                      WORD_W'(item_count));
                    if (status !== want.status)
                        note_mismatch("status", WORD_W'(want.status), WORD_W'(status));
                end
            end
            if (in_valid && in_ready)
            begin
                req_fire = 1'b1;
                req_taken <= req_taken + 1;
                req.op = operation;
                req.value = value;
                want = deque_apply(req);
                expected_res.push_back(want);
                if (want.status == ST_OVERFLOW)
                    overflow_hits++;
                if (want.status == ST_UNDERFLOW)
                    underflow_hits++;
                if (int'(ring_fill) > peak_fill)
                    peak_fill = int'(ring_fill);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        int made;
        int len;

        // directed: empty-queue corners, spare codes, extreme words at both
        // ends, then unwinding back to empty
        pending_reqs.push_back(make_req(OP_REMOVE_FRONT, 32'sh1234_5678));
        pending_reqs.push_back(make_req(OP_REMOVE_BACK, -32'sd1));
        pending_reqs.push_back(make_req(OP_PEEK, 32'sh7FFF_FFFF));
        pending_reqs.push_back(make_req(OP_SPARE_FIRST, 32'sh8000_0000));
        pending_reqs.push_back(make_req(OP_SPARE_FIRST + 3'd1, -32'sd1));
        pending_reqs.push_back(make_req(OP_SPARE_LAST, 32'sh5555_5555));
        pending_reqs.push_back(make_req(OP_ADD_BACK, 32'sh7FFF_FFFF));
        pending_reqs.push_back(make_req(OP_ADD_FRONT, 32'sh8000_0000));
        pending_reqs.push_back(make_req(OP_ADD_BACK, 32'sh0000_0000));
        pending_reqs.push_back(make_req(OP_ADD_FRONT, -32'sd1));
        pending_reqs.push_back(make_req(OP_PEEK, 32'sh0000_0000));
        pending_reqs.push_back(make_req(OP_REMOVE_BACK, 32'sh0000_0000));
        pending_reqs.push_back(make_req(OP_REMOVE_FRONT, 32'sh0000_0000));
        pending_reqs.push_back(make_req(OP_REMOVE_BACK, 32'sh0000_0000));
        pending_reqs.push_back(make_req(OP_REMOVE_FRONT, 32'sh0000_0000));
        pending_reqs.push_back(make_req(OP_REMOVE_FRONT, 32'sh0000_0000));
        pending_reqs.push_back(make_req(OP_ADD_FRONT, 32'sh5555_5555));
        pending_reqs.push_back(make_req(OP_ADD_BACK, 32'shAAAA_AAAA));
        pending_reqs.push_back(make_req(OP_SPARE_LAST, 32'shAAAA_AAAA));
        pending_reqs.push_back(make_req(OP_REMOVE_FRONT, 32'sh0000_0000));
        pending_reqs.push_back(make_req(OP_REMOVE_BACK, 32'sh0000_0000));

        // random: a full fill past the top, a full drain past the bottom,
        // then segments of each flavor until the budget is used
        queue_segment(SEG_FILL, 320);
        queue_segment(SEG_DRAIN, 320);
        made = 640;
        while (made < RANDOM_ITEMS)
        begin
            len = $urandom_range(20, 300);
            if (len > RANDOM_ITEMS - made)
                len = RANDOM_ITEMS - made;
            queue_segment($urandom_range(SEG_FILL, SEG_MIXED), len);
            made += len;
        end
        req_total = pending_reqs.size();
        hold_at = (2 * req_total) / 3 + 40;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // all requests out, then all results back, then a short drain
        while (pending_reqs.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_res.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_res.size() != 0)
            note_mismatch("results still outstanding at end", expected_res.size(), '0);

        $display("ran %0d requests, checked %0d results, %0d mismatches",
                 req_taken, res_checked, error_count);
        $display("overflows %0d, underflows %0d, peak occupancy %0d of %0d",
                 overflow_hits, underflow_hits, peak_fill, RING_SLOTS);
        if (error_count == 0)
            $display("double_ended_queue_tb: PASS");
        else
            $display("double_ended_queue_tb: FAIL");
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("timeout with %0d results still expected", expected_res.size());
        $display("double_ended_queue_tb: FAIL");
        $finish;
    end

endmodule
